// ===== hw/rtl/osm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_pkg
// Shared constants, types and helpers for the order statistic multiset.
// ----------------------------------------------------------------------------
package osm_pkg;

  localparam int LEAF_COUNT  = 1024;
  localparam int COUNT_W     = 20;
  localparam int RANK_W      = COUNT_W;
  localparam int VALUE_W     = $clog2(LEAF_COUNT);
  localparam int LEVELS      = VALUE_W;
  localparam int NODE_TOTAL  = 2 * LEAF_COUNT - 1;
  localparam int NODE_W      = VALUE_W + 1;
  localparam int LVL_W       = $clog2(LEVELS + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_BAD_RANK
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [VALUE_W-1:0] value;
    logic [RANK_W-1:0]  rank;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    WALK_INSERT,
    WALK_DELETE,
    WALK_MIN
  } walk_t;

  // Heap index of the node at position pos of tree level lvl (root is level 0).
  function automatic logic [NODE_W-1:0] node_addr(input logic [LVL_W-1:0]  lvl,
                                                  input logic [NODE_W-1:0] pos);
    logic [NODE_W-1:0] base;
    base = (NODE_W'(1) << lvl) - NODE_W'(1);
    return base + pos;
  endfunction

endpackage

// ===== hw/rtl/osm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module osm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/osm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_front
// Input stage: takes words from the input channel, classifies them as
// insert, delete or bad rank, and pushes them toward the command queue.
// ----------------------------------------------------------------------------
module osm_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clearing,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [osm_pkg::VALUE_W-1:0]  in_insert_value,
  input  logic [osm_pkg::RANK_W-1:0]   in_rank,
  output logic                         push_valid,
  input  logic                         push_ready,
  output osm_pkg::item_t               push_item
);
  import osm_pkg::*;

  logic  stg_valid_r;
  logic  stg_valid_nxt;
  item_t stg_item_r;
  item_t stg_item_nxt;
  logic  take;

  // Nothing is taken while the count memory is being cleared.
  assign in_ready = !clearing && (!stg_valid_r || push_ready);
  assign take     = in_valid && in_ready;

  always_comb begin
    stg_item_nxt       = stg_item_r;
    stg_item_nxt.value = in_insert_value;
    stg_item_nxt.rank  = in_rank;
    if (!in_mode) begin
      stg_item_nxt.op = OP_INSERT;
    end else if (in_rank == '0) begin
      stg_item_nxt.op = OP_BAD_RANK;
    end else begin
      stg_item_nxt.op = OP_DELETE;
    end
    stg_valid_nxt = take || (stg_valid_r && !push_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_item_r <= stg_item_nxt;
    end
  end

  assign push_valid = stg_valid_r;
  assign push_item  = stg_item_r;

endmodule

// ===== hw/rtl/osm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_queue
// Short command queue between the input stage and the tree sequencer.
// ----------------------------------------------------------------------------
module osm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  osm_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output osm_pkg::item_t pop_item
);
  import osm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [PTR_W:0]   fill_r;
  logic [PTR_W:0]   fill_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (fill_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  // Depth is a power of two, so the pointers wrap by themselves.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/osm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_back
// Tree sequencer: clears the count memory after reset, then walks the count
// tree one level per cycle for each command and drives the result register.
// ----------------------------------------------------------------------------
module osm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         clearing,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  osm_pkg::item_t               q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [osm_pkg::VALUE_W-1:0]  out_removed_value,
  output logic [osm_pkg::VALUE_W-1:0]  out_smallest_value,
  output logic [osm_pkg::COUNT_W-1:0]  out_total_count,
  output logic                         out_error
);
  import osm_pkg::*;

  state_t             state_r,    state_nxt;
  walk_t              walk_r,     walk_nxt;
  logic [NODE_W-1:0]  clr_r,      clr_nxt;
  logic [COUNT_W-1:0] root_r,     root_nxt;
  logic [VALUE_W-1:0] min_r,      min_nxt;
  logic [LVL_W-1:0]   lvl_r,      lvl_nxt;
  logic [VALUE_W-1:0] pos_r,      pos_nxt;
  logic [COUNT_W-1:0] cur_r,      cur_nxt;
  logic [COUNT_W-1:0] kth_r,      kth_nxt;
  logic [VALUE_W-1:0] ins_sh_r,   ins_sh_nxt;
  logic [VALUE_W-1:0] removed_r,  removed_nxt;
  logic               err_r,      err_nxt;
  logic               need_min_r, need_min_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic [VALUE_W-1:0] out_removed_r;
  logic [VALUE_W-1:0] out_smallest_r;
  logic [COUNT_W-1:0] out_total_r;
  logic               out_error_r;

  logic               mem_we;
  logic [NODE_W-1:0]  mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic [NODE_W-1:0]  mem_raddr;
  logic [COUNT_W-1:0] mem_rdata;

  logic               walk_bit;
  logic               next_bit;
  logic [LVL_W-1:0]   child_lvl;
  logic [NODE_W-1:0]  child_pos;

  osm_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NODE_TOTAL)
  ) u_count_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    walk_nxt     = walk_r;
    clr_nxt      = clr_r;
    root_nxt     = root_r;
    min_nxt      = min_r;
    lvl_nxt      = lvl_r;
    pos_nxt      = pos_r;
    cur_nxt      = cur_r;
    kth_nxt      = kth_r;
    ins_sh_nxt   = ins_sh_r;
    removed_nxt  = removed_r;
    err_nxt      = err_r;
    need_min_nxt = need_min_r;
    out_load     = 1'b0;
    q_ready      = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = '0;

    // The root count lives in root_r; the memory read returns the count of a
    // child of the current node. A delete descends by rank, an insert by the
    // bits of its value, and either one writes the updated child count back
    // as it passes.
    child_lvl = lvl_r + 1'b1;
    if (walk_r == WALK_INSERT) begin
      walk_bit = ins_sh_r[VALUE_W-1];
      next_bit = ins_sh_r[VALUE_W-2];
    end else begin
      walk_bit = (kth_r > mem_rdata);
      next_bit = 1'b0;
    end
    child_pos = {pos_r, walk_bit};

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == NODE_W'(NODE_TOTAL - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          removed_nxt  = '0;
          err_nxt      = 1'b0;
          need_min_nxt = 1'b0;
          lvl_nxt      = '0;
          pos_nxt      = '0;
          ins_sh_nxt   = q_item.value;
          kth_nxt      = q_item.rank;
          cur_nxt      = root_r;
          state_nxt    = ST_ISSUE;
          case (q_item.op)
            OP_INSERT: begin
              walk_nxt = WALK_INSERT;
              if (root_r == COUNT_MAX) begin
                err_nxt   = 1'b1;
                state_nxt = ST_FINISH;
              end else begin
                root_nxt = root_r + 1'b1;
                if (root_r == '0 || q_item.value < min_r) begin
                  min_nxt = q_item.value;
                end
              end
            end
            OP_DELETE: begin
              walk_nxt = WALK_DELETE;
              if (q_item.rank > root_r) begin
                err_nxt   = 1'b1;
                state_nxt = ST_FINISH;
              end else begin
                root_nxt = root_r - 1'b1;
                // Only removing the smallest element can move the minimum.
                need_min_nxt = (q_item.rank == RANK_W'(1)) && (root_r != COUNT_W'(1));
              end
            end
            default: begin
              err_nxt   = 1'b1;
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      ST_ISSUE: begin
        mem_raddr = node_addr(child_lvl, {pos_r, (walk_r == WALK_INSERT) ?
                                          ins_sh_r[VALUE_W-1] : 1'b0});
        state_nxt = ST_WALK;
      end

      ST_WALK: begin
        mem_we    = (walk_r != WALK_MIN);
        mem_waddr = node_addr(child_lvl, child_pos);
        if (walk_r == WALK_INSERT) begin
          mem_wdata = mem_rdata + 1'b1;
        end else if (walk_bit) begin
          mem_wdata = cur_r - mem_rdata - 1'b1;
        end else begin
          mem_wdata = mem_rdata - 1'b1;
        end
        if (walk_bit) begin
          kth_nxt = kth_r - mem_rdata;
          cur_nxt = cur_r - mem_rdata;
        end else begin
          cur_nxt = mem_rdata;
        end
        pos_nxt    = child_pos[VALUE_W-1:0];
        ins_sh_nxt = ins_sh_r << 1;
        lvl_nxt    = child_lvl;
        if (child_lvl == LVL_W'(LEVELS)) begin
          state_nxt = ST_FINISH;
          case (walk_r)
            WALK_DELETE: begin
              removed_nxt = child_pos[VALUE_W-1:0];
              if (need_min_r) begin
                walk_nxt  = WALK_MIN;
                lvl_nxt   = '0;
                pos_nxt   = '0;
                kth_nxt   = COUNT_W'(1);
                cur_nxt   = root_r;
                state_nxt = ST_ISSUE;
              end
            end
            WALK_MIN: begin
              min_nxt = child_pos[VALUE_W-1:0];
            end
            default: begin
            end
          endcase
        end else begin
          mem_raddr = node_addr(child_lvl + 1'b1, {child_pos[VALUE_W-1:0], next_bit});
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r     <= walk_nxt;
    min_r      <= min_nxt;
    lvl_r      <= lvl_nxt;
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    kth_r      <= kth_nxt;
    ins_sh_r   <= ins_sh_nxt;
    removed_r  <= removed_nxt;
    err_r      <= err_nxt;
    need_min_r <= need_min_nxt;
    if (out_load) begin
      out_removed_r  <= removed_r;
      out_smallest_r <= (root_r == '0) ? '0 : min_r;
      out_total_r    <= root_r;
      out_error_r    <= err_r;
    end
  end

  assign clearing           = (state_r == ST_CLEAR);
  assign out_valid          = out_valid_r;
  assign out_removed_value  = out_removed_r;
  assign out_smallest_value = out_smallest_r;
  assign out_total_count    = out_total_r;
  assign out_error          = out_error_r;

  a_walk_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (lvl_r < LVL_W'(LEVELS)))
    else $error("tree walk went below the leaf level");

  a_root_only_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r) != ST_IDLE) |-> $stable(root_r))
    else $error("total count changed outside command dispatch");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || (state_r == ST_WALK && walk_r != WALK_MIN)))
    else $error("count memory written outside clear or update walk");

  a_error_removes_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_removed_r == '0))
    else $error("refused command reports a removed value");

  a_empty_smallest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_total_r == '0) |-> (out_smallest_r == '0))
    else $error("empty multiset reports a nonzero smallest value");

endmodule

// ===== hw/rtl/order_statistic_multiset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset
// Multiset of 10-bit values with insert and delete-by-rank, kept as a binary
// tree of element counts in one memory.
// ----------------------------------------------------------------------------
// After reset the block clears its 2047-entry count memory, one entry per
// cycle, and takes no word until the clear is done. Each word then
// passes an input register and a two-entry command queue into the tree
// sequencer, which walks the count tree one level per cycle, limited by the
// single read port of the count memory. A refused word skips the walk, and
// a delete of rank 1 that leaves elements behind walks the tree a second
// time to find the new smallest value. Results leave through an output
// register, so the sequencer starts on the next word while a result waits
// to be taken.
module order_statistic_multiset (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [osm_pkg::VALUE_W-1:0]  in_insert_value,
  input  logic [osm_pkg::RANK_W-1:0]   in_rank,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [osm_pkg::VALUE_W-1:0]  out_removed_value,
  output logic [osm_pkg::VALUE_W-1:0]  out_smallest_value,
  output logic [osm_pkg::COUNT_W-1:0]  out_total_count,
  output logic                         out_error
);
  import osm_pkg::*;

  logic  clearing;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  osm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .clearing        (clearing),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_insert_value (in_insert_value),
    .in_rank         (in_rank),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  osm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  osm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .clearing           (clearing),
    .q_valid            (pop_valid),
    .q_ready            (pop_ready),
    .q_item             (pop_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_removed_value  (out_removed_value),
    .out_smallest_value (out_smallest_value),
    .out_total_count    (out_total_count),
    .out_error          (out_error)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the order statistic multiset. A short table of
// words covers refused deletes, value extremes, the smallest-value refresh
// and draining to empty. A long random run follows, with fill and drain
// phases. Each result is checked against its typed table row if it has one,
// else against a value histogram that the bench keeps alongside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import osm_pkg::*;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;
  localparam int   NUM_DIRECTED = 24;
  localparam int   NUM_RANDOM   = 1600;
  localparam logic [RANK_W-1:0] RANK_TOP = {RANK_W{1'b1}};

  typedef struct packed {
    logic [VALUE_W-1:0] removed;
    logic [VALUE_W-1:0] smallest;
    logic [COUNT_W-1:0] total;
    logic               err;
  } result_t;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
    logic [RANK_W-1:0]  rank;
    logic               typed;
    result_t            want;
  } stim_row_t;

  localparam result_t REFUSED_EMPTY = '{10'd0, 10'd0, 20'd0, 1'b1};
  localparam result_t FROM_MODEL    = '{10'd0, 10'd0, 20'd0, 1'b0};

  // Rows with typed set carry their result; the rest use the histogram.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{MODE_DELETE, 10'h3FF, 20'd1,      1'b1, REFUSED_EMPTY},
    '{MODE_DELETE, 10'h000, 20'd0,      1'b1, REFUSED_EMPTY},
    '{MODE_DELETE, 10'h155, RANK_TOP,   1'b1, REFUSED_EMPTY},
    '{MODE_INSERT, 10'd0,   RANK_TOP,   1'b1, '{10'd0, 10'd0, 20'd1, 1'b0}},
    '{MODE_INSERT, 10'd1023, 20'd0,     1'b1, '{10'd0, 10'd0, 20'd2, 1'b0}},
    '{MODE_DELETE, 10'd0,   20'd2,      1'b1, '{10'd1023, 10'd0, 20'd1, 1'b0}},
    '{MODE_DELETE, 10'd0,   20'd1,      1'b1, '{10'd0, 10'd0, 20'd0, 1'b0}},
    '{MODE_INSERT, 10'd1023, 20'hAAAAA, 1'b1, '{10'd0, 10'd1023, 20'd1, 1'b0}},
    '{MODE_INSERT, 10'd512, 20'h55555,  1'b1, '{10'd0, 10'd512, 20'd2, 1'b0}},
    '{MODE_INSERT, 10'd512, 20'd0,      1'b1, '{10'd0, 10'd512, 20'd3, 1'b0}},
    '{MODE_INSERT, 10'd1,   20'd0,      1'b1, '{10'd0, 10'd1, 20'd4, 1'b0}},
    '{MODE_INSERT, 10'h2AA, 20'd0,      1'b0, FROM_MODEL},
    '{MODE_INSERT, 10'h155, 20'd0,      1'b0, FROM_MODEL},
    '{MODE_DELETE, 10'd0,   20'd0,      1'b0, FROM_MODEL},
    '{MODE_DELETE, 10'd0,   20'd7,      1'b0, FROM_MODEL},
    '{MODE_DELETE, 10'd0,   20'd1,      1'b0, FROM_MODEL},
    '{MODE_DELETE, 10'd0,   20'd3,      1'b0, FROM_MODEL},
    '{MODE_DELETE, 10'd0,   20'd4,      1'b0, FROM_MODEL},
    '{MODE_INSERT, 10'd0,   20'd0,      1'b0, FROM_MODEL},
    '{MODE_DELETE, 10'd0,   20'd1,      1'b0, FROM_MODEL},
    '{MODE_DELETE, 10'd0,   20'd1,      1'b0, FROM_MODEL},
    '{MODE_DELETE, 10'd0,   20'd1,      1'b0, FROM_MODEL},
    '{MODE_DELETE, 10'd0,   20'd1,      1'b0, FROM_MODEL},
    '{MODE_DELETE, 10'd0,   20'd1,      1'b1, REFUSED_EMPTY}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_mode;
  logic [VALUE_W-1:0] in_insert_value;
  logic [RANK_W-1:0]  in_rank;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VALUE_W-1:0] out_removed_value;
  logic [VALUE_W-1:0] out_smallest_value;
  logic [COUNT_W-1:0] out_total_count;
  logic               out_error;

  int unsigned        value_count [LEAF_COUNT];
  logic [COUNT_W-1:0] held_total;
  result_t            pending_results [$];
  int                 mismatch_count = 0;
  int                 burst_left;
  int                 stall_style = 0;
  int                 stall_span = 0;

  order_statistic_multiset uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_insert_value    (in_insert_value),
    .in_rank            (in_rank),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_removed_value  (out_removed_value),
    .out_smallest_value (out_smallest_value),
    .out_total_count    (out_total_count),
    .out_error          (out_error)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Applies one accepted word to the histogram and returns the result it owes.
  function automatic result_t apply_word(input logic mode,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [RANK_W-1:0] rank);
    result_t     res;
    int unsigned left;
    int          v;
    res = '0;
    if (mode == MODE_INSERT) begin
      if (held_total == COUNT_MAX) begin
        res.err = 1'b1;
      end else begin
        value_count[value]++;
        held_total++;
      end
    end else if (rank == '0 || rank > held_total) begin
      res.err = 1'b1;
    end else begin
      left = 32'(rank);
      v = 0;
      while (left > value_count[v]) begin
        left -= value_count[v];
        v++;
      end
      value_count[v]--;
      held_total--;
      res.removed = v[VALUE_W-1:0];
    end
    res.total = held_total;
    if (held_total != '0) begin
      v = 0;
      while (value_count[v] == 0) v++;
      res.smallest = v[VALUE_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Holds the word until it is taken, then either keeps the burst going or idles.
  task automatic send_word(input logic mode, input logic [VALUE_W-1:0] value,
                           input logic [RANK_W-1:0] rank, input logic typed,
                           input result_t typed_res);
    result_t res;
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_insert_value <= value;
    in_rank         <= rank;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_word(mode, value, rank);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
                                                 $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // The receiver switches between always ready, random stalls and long stalls.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_span  <= $urandom_range(20, 150);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready <= stall_span[3];
      end
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing pending", out_total_count, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_removed_value !== want.removed)
          report_mismatch("removed_value", COUNT_W'(out_removed_value),
                          COUNT_W'(want.removed));
        if (out_smallest_value !== want.smallest)
          report_mismatch("smallest_value", COUNT_W'(out_smallest_value),
                          COUNT_W'(want.smallest));
        if (out_total_count !== want.total)
          report_mismatch("total_count", out_total_count, want.total);
        if (out_error !== want.err)
          report_mismatch("error", COUNT_W'(out_error), COUNT_W'(want.err));
      end
    end
  end

  initial begin
    logic               mode;
    logic [VALUE_W-1:0] value;
    logic [RANK_W-1:0]  rank;
    int                 pick;
    bit                 filling;
    int                 pool [4];
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = MODE_INSERT;
    in_insert_value = '0;
    in_rank         = '0;
    burst_left      = 0;
    held_total      = '0;
    filling         = 1'b1;
    foreach (value_count[i]) value_count[i] = 0;
    foreach (pool[i]) pool[i] = $urandom_range(0, LEAF_COUNT - 1);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_word(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].rank,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // Alternate between growing and shrinking the multiset, with a fresh
      // set of popular values each phase so duplicates pile up.
      if (i % 150 == 0) begin
        filling = !filling || (held_total < 20);
        foreach (pool[j]) pool[j] = $urandom_range(0, LEAF_COUNT - 1);
      end
      value = VALUE_W'($urandom_range(0, LEAF_COUNT - 1));
      rank  = RANK_W'($urandom_range(0, RANK_TOP));
      pick  = $urandom_range(0, 99);
      if (held_total == '0)
        mode = (pick < 85) ? MODE_INSERT : MODE_DELETE;
      else
        mode = (pick < (filling ? 70 : 30)) ? MODE_INSERT : MODE_DELETE;
      pick = $urandom_range(0, 99);
      if (mode == MODE_INSERT) begin
        if (pick < 40)
          value = VALUE_W'(pool[$urandom_range(0, 3)]);
        else if (pick < 45)
          value = '0;
        else if (pick < 50)
          value = VALUE_W'(LEAF_COUNT - 1);
      end else begin
        if (pick < 8 || held_total == '0)
          rank = (held_total == '0 && pick >= 8) ? rank : '0;
        else if (pick < 16)
          rank = RANK_W'($urandom_range(held_total + 1, RANK_TOP));
        else if (pick < 32)
          rank = RANK_W'(1);
        else if (pick < 42)
          rank = held_total;
        else
          rank = RANK_W'($urandom_range(1, held_total));
      end
      send_word(mode, value, rank, 1'b0, FROM_MODEL);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("order_statistic_multiset test passed");
    else
      $display("order_statistic_multiset test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("order_statistic_multiset test failed");
    $finish;
  end

endmodule
